// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("concurrent assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("concurrent assertion failed");

`endif

// ===== sv/ema_pkg.sv =====
// Types, constants and helpers for the exponential moving average block.
package ema_pkg;

  localparam int SampleWidth  = 32;
  localparam int PeriodWidth  = 11;
  localparam int MaxPeriod    = 1024;
  localparam int PeriodResetN = 10;
  localparam int SumWidth     = 42;
  localparam int WeightFrac   = 24;
  localparam int WeightBits   = WeightFrac + 1;
  localparam int DivisorWidth = PeriodWidth + 1;
  localparam int DiffWidth    = SampleWidth + 1;
  localparam int DivSteps     = SumWidth;
  localparam int MulSteps     = WeightBits;
  localparam int CntWidth     = $clog2(DivSteps + 1);
  localparam int AddrWidth    = 3;
  localparam int DataWidth    = 32;

  localparam logic [PeriodWidth-1:0] PeriodReset = PeriodWidth'(PeriodResetN);
  localparam logic [WeightBits-1:0]  WeightReset =
    WeightBits'((2 ** (WeightFrac + 1)) / (PeriodResetN + 1));
  localparam logic [SumWidth-1:0]    WeightNum = SumWidth'(1) << (WeightFrac + 1);

  typedef enum logic [0:0] {
    RegPeriod = 1'b0
  } reg_idx_e;

  typedef enum logic [0:0] {
    OpDiv = 1'b0,
    OpMul = 1'b1
  } unit_op_e;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StWeight = 4'b0010,
    StMean   = 4'b0100,
    StUpdate = 4'b1000
  } state_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Clamp the period register into the usable range.
  function automatic logic [PeriodWidth-1:0] eff_period(input logic [PeriodWidth-1:0] p);
    logic [PeriodWidth-1:0] e;
    e = p;
    if (p == '0) begin
      e = PeriodWidth'(1);
    end else if (p > PeriodWidth'(MaxPeriod)) begin
      e = PeriodWidth'(MaxPeriod);
    end
    return e;
  endfunction

endpackage

// ===== sv/ema_if.sv =====
// Stream interfaces for the sample input and the average output.
interface ema_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [ema_pkg::SampleWidth-1:0]   sample;
  logic                                     missing;

  modport source (output valid, output sample, output missing, input ready);
  modport sink   (input valid, input sample, input missing, output ready);
endinterface

interface ema_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [ema_pkg::SampleWidth-1:0]   average;
  logic                                     valid_res;

  modport source (output valid, output average, output valid_res, input ready);
  modport sink   (input valid, input average, input valid_res, output ready);
endinterface

// ===== sv/exponential_moving_average.sv =====
// Skipped, poisoned or mid-seed samples are answered from the output register in the
// next cycle; the seed-completing sample goes through StMean, each later one through
// StUpdate, before the output register. One sample at a time uses the shared bit-serial unit
// (42 divide steps for the seed mean, 25 multiply steps per update).
// A period write recomputes the weight on that unit, with input held off meanwhile.
// Reset (async, active low): period 10, weight preset, stream state cleared, ready at once.
module exponential_moving_average (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ema_in_if.sink                            in_if,
  ema_out_if.source                         out_if,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ema_pkg::AddrWidth-1:0]     paddr,
  input  logic [ema_pkg::DataWidth-1:0]     pwdata,
  output logic [ema_pkg::DataWidth-1:0]     prdata,
  output logic                              pready
);

  localparam int SW = ema_pkg::SampleWidth;

  ema_pkg::state_e                          state_q, state_d;
  logic [ema_pkg::PeriodWidth-1:0]          period_q, period_d;
  logic [ema_pkg::WeightBits-1:0]           weight_q, weight_d;
  logic [ema_pkg::PeriodWidth-1:0]          seed_cnt_q, seed_cnt_d;
  logic signed [ema_pkg::SumWidth-1:0]      seed_sum_q, seed_sum_d;
  logic signed [SW-1:0]                     avg_q, avg_d;
  logic                                     started_q, started_d;
  logic                                     poisoned_q, poisoned_d;
  logic                                     neg_q, neg_d;
  logic                                     out_vld_q, out_vld_d;
  logic signed [SW-1:0]                     out_avg_q, out_avg_d;
  logic                                     out_res_q, out_res_d;

  ema_pkg::unit_ctrl_t                      ctrl;
  ema_pkg::unit_stat_t                      stat;
  logic [ema_pkg::SumWidth-1:0]             dividend, result;
  logic [ema_pkg::DivisorWidth-1:0]         divisor;
  logic signed [ema_pkg::DiffWidth-1:0]     diff;

  logic                                     cfg_wr, in_ready, acc, seed_done;
  logic [ema_pkg::PeriodWidth-1:0]          cnt_nxt, eff, eff_new;
  logic signed [ema_pkg::SumWidth-1:0]      sum_nxt;
  logic [ema_pkg::SumWidth-1:0]             sum_mag;
  logic [SW-1:0]                            mean_mag;
  logic signed [SW+2:0]                     upd_sum;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (ema_pkg::reg_idx_e'(paddr[ema_pkg::AddrWidth-1]) == ema_pkg::RegPeriod);
  assign prdata = (ema_pkg::reg_idx_e'(paddr[ema_pkg::AddrWidth-1]) == ema_pkg::RegPeriod)
                ? {{(ema_pkg::DataWidth-ema_pkg::PeriodWidth){1'b0}}, period_q} : '0;

  // Take a new transaction only when idle and the output register is free or draining.
  assign in_ready = (state_q == ema_pkg::StIdle) && (!out_vld_q || out_if.ready);
  assign acc      = in_if.valid && in_ready;
  assign in_if.ready = in_ready;

  assign out_if.valid     = out_vld_q;
  assign out_if.average   = out_avg_q;
  assign out_if.valid_res = out_res_q;

  always_comb begin
    eff       = ema_pkg::eff_period(period_q);
    eff_new   = ema_pkg::eff_period(pwdata[ema_pkg::PeriodWidth-1:0]);
    sum_nxt   = seed_sum_q +
                {{(ema_pkg::SumWidth-SW){in_if.sample[SW-1]}}, in_if.sample};
    cnt_nxt   = seed_cnt_q + ema_pkg::PeriodWidth'(1);
    seed_done = (cnt_nxt == '0) || (cnt_nxt >= eff);
    sum_mag   = sum_nxt[ema_pkg::SumWidth-1] ? -sum_nxt : sum_nxt;
    diff      = {in_if.sample[SW-1], in_if.sample} - {avg_q[SW-1], avg_q};
    mean_mag  = result[SW-1:0];
    upd_sum   = {{3{avg_q[SW-1]}}, avg_q} +
                {result[ema_pkg::DiffWidth], result[ema_pkg::DiffWidth:0]};

    dividend  = cfg_wr ? ema_pkg::WeightNum : sum_mag;
    divisor   = cfg_wr ? ({1'b0, eff_new} + ema_pkg::DivisorWidth'(1))
              : ((cnt_nxt == '0) ? ema_pkg::DivisorWidth'(1 << ema_pkg::PeriodWidth)
                                 : {1'b0, cnt_nxt});

    ctrl.start = 1'b0;
    ctrl.op    = ema_pkg::OpDiv;

    state_d    = state_q;
    period_d   = period_q;
    weight_d   = weight_q;
    seed_cnt_d = seed_cnt_q;
    seed_sum_d = seed_sum_q;
    avg_d      = avg_q;
    started_d  = started_q;
    poisoned_d = poisoned_q;
    neg_d      = neg_q;
    out_vld_d  = out_vld_q && !out_if.ready;
    out_avg_d  = out_avg_q;
    out_res_d  = out_res_q;

    if (cfg_wr) begin
      period_d   = pwdata[ema_pkg::PeriodWidth-1:0];
      ctrl.start = 1'b1;
      state_d    = ema_pkg::StWeight;
    end

    unique case (state_q)
      ema_pkg::StIdle: begin
        if (acc) begin
          priority if (poisoned_q) begin
            out_vld_d = 1'b1;
            out_avg_d = '0;
            out_res_d = 1'b0;
          end else if (in_if.missing) begin
            if (seed_cnt_q != '0 || started_q) begin
              poisoned_d = 1'b1;
            end
            out_vld_d = 1'b1;
            out_avg_d = '0;
            out_res_d = 1'b0;
          end else if (!started_q) begin
            seed_sum_d = sum_nxt;
            seed_cnt_d = cnt_nxt;
            if (seed_done) begin
              neg_d      = sum_nxt[ema_pkg::SumWidth-1];
              ctrl.start = 1'b1;
              ctrl.op    = ema_pkg::OpDiv;
              state_d    = ema_pkg::StMean;
            end else begin
              out_vld_d = 1'b1;
              out_avg_d = '0;
              out_res_d = 1'b0;
            end
          end else begin
            ctrl.start = 1'b1;
            ctrl.op    = ema_pkg::OpMul;
            state_d    = ema_pkg::StUpdate;
          end
        end
      end
      ema_pkg::StWeight: begin
        if (stat.done) begin
          weight_d = result[ema_pkg::WeightBits-1:0];
          state_d  = ema_pkg::StIdle;
        end
      end
      ema_pkg::StMean: begin
        if (stat.done) begin
          // Divide ran on the magnitude; restore the sign (truncation toward zero).
          avg_d     = neg_q ? -$signed(mean_mag) : $signed(mean_mag);
          started_d = 1'b1;
          out_vld_d = 1'b1;
          out_avg_d = avg_d;
          out_res_d = 1'b1;
          state_d   = ema_pkg::StIdle;
        end
      end
      ema_pkg::StUpdate: begin
        if (stat.done) begin
          // Saturate as a safeguard; the weight keeps the sum in range.
          if (upd_sum[SW+2:SW-1] == '0 || upd_sum[SW+2:SW-1] == '1) begin
            avg_d = upd_sum[SW-1:0];
          end else if (upd_sum[SW+2]) begin
            avg_d = {1'b1, {(SW-1){1'b0}}};
          end else begin
            avg_d = {1'b0, {(SW-1){1'b1}}};
          end
          out_vld_d = 1'b1;
          out_avg_d = avg_d;
          out_res_d = 1'b1;
          state_d   = ema_pkg::StIdle;
        end
      end
      default: state_d = ema_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ema_pkg::StIdle;
      period_q   <= ema_pkg::PeriodReset;
      weight_q   <= ema_pkg::WeightReset;
      seed_cnt_q <= '0;
      seed_sum_q <= '0;
      avg_q      <= '0;
      started_q  <= 1'b0;
      poisoned_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      period_q   <= period_d;
      weight_q   <= weight_d;
      seed_cnt_q <= seed_cnt_d;
      seed_sum_q <= seed_sum_d;
      avg_q      <= avg_d;
      started_q  <= started_d;
      poisoned_q <= poisoned_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q     <= neg_d;
    out_avg_q <= out_avg_d;
    out_res_q <= out_res_d;
  end

  ema_serial_unit u_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .mcand_i    (diff),
    .mplier_i   (weight_q),
    .stat_o     (stat),
    .result_o   (result)
  );

endmodule

// ===== sv/ema_serial_unit.sv =====
// Shared bit-serial unit: restoring divider and shift-add multiplier.
module ema_serial_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ema_pkg::unit_ctrl_t                   ctrl_i,
  input  logic [ema_pkg::SumWidth-1:0]          dividend_i,
  input  logic [ema_pkg::DivisorWidth-1:0]      divisor_i,
  input  logic signed [ema_pkg::DiffWidth-1:0]  mcand_i,
  input  logic [ema_pkg::WeightBits-1:0]        mplier_i,
  output ema_pkg::unit_stat_t                   stat_o,
  output logic [ema_pkg::SumWidth-1:0]          result_o
);

  logic                                  busy_q, done_q;
  logic [ema_pkg::CntWidth-1:0]          cnt_q;
  ema_pkg::unit_op_e                     op_q;
  logic [ema_pkg::SumWidth-1:0]          quo_q;
  logic [ema_pkg::DivisorWidth-1:0]      rem_q, dvs_q;
  logic signed [ema_pkg::DiffWidth-1:0]  hi_q, mc_q;
  logic [ema_pkg::WeightBits-1:0]        lo_q;

  logic [ema_pkg::DivisorWidth:0]        r_sh, r_sub;
  logic                                  fits;
  logic signed [ema_pkg::DiffWidth:0]    msum;

  always_comb begin
    r_sh  = {rem_q, quo_q[ema_pkg::SumWidth-1]};
    fits  = r_sh >= {1'b0, dvs_q};
    r_sub = r_sh - {1'b0, dvs_q};
    // Add the multiplicand when the current multiplier bit is set.
    msum  = {hi_q[ema_pkg::DiffWidth-1], hi_q} +
            (lo_q[0] ? {mc_q[ema_pkg::DiffWidth-1], mc_q} : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= (ctrl_i.op == ema_pkg::OpDiv) ? ema_pkg::CntWidth'(ema_pkg::DivSteps)
                                              : ema_pkg::CntWidth'(ema_pkg::MulSteps);
    end else if (busy_q) begin
      cnt_q <= cnt_q - ema_pkg::CntWidth'(1);
      if (cnt_q == ema_pkg::CntWidth'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      op_q  <= ctrl_i.op;
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
      hi_q  <= '0;
      lo_q  <= mplier_i;
      mc_q  <= mcand_i;
    end else if (busy_q) begin
      unique case (op_q)
        ema_pkg::OpDiv: begin
          rem_q <= fits ? r_sub[ema_pkg::DivisorWidth-1:0] : r_sh[ema_pkg::DivisorWidth-1:0];
          quo_q <= {quo_q[ema_pkg::SumWidth-2:0], fits};
        end
        ema_pkg::OpMul: begin
          // Shift the partial product right, low bits retire into lo_q.
          hi_q <= msum[ema_pkg::DiffWidth:1];
          lo_q <= {msum[0], lo_q[ema_pkg::WeightBits-1:1]};
        end
        default: ;
      endcase
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  // Quotient for a divide; for a multiply, the product shifted right by the weight fraction, floor rounding.
  assign result_o = (op_q == ema_pkg::OpDiv) ? quo_q :
    {{(ema_pkg::SumWidth-ema_pkg::DiffWidth-1){hi_q[ema_pkg::DiffWidth-1]}},
     hi_q, lo_q[ema_pkg::WeightBits-1]};

endmodule

// ===== sv/ema_checker.sv =====
// Port-level checker for the exponential moving average block, with its bind.
`include "assert_macros.svh"

module ema_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic [ema_pkg::SampleWidth-1:0]     average_i,
  input logic                                valid_res_i,
  input logic                                psel_i,
  input logic                                penable_i,
  input logic                                pwrite_i,
  input logic [ema_pkg::AddrWidth-1:0]       paddr_i
);

  logic [1:0] pending_q;
  logic       in_acc, out_acc, cfg_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign cfg_acc = psel_i && penable_i && pwrite_i &&
                   (ema_pkg::reg_idx_e'(paddr_i[ema_pkg::AddrWidth-1]) == ema_pkg::RegPeriod);

  // Count transactions accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(average_i) && $stable(valid_res_i))
  `ASSERT_IMPLIES(a_one_in_flight, clk_i, rst_ni, in_acc, pending_q == 2'd0 || out_acc)
  `ASSERT_IMPLIES(a_out_has_source, clk_i, rst_ni, out_valid_i, pending_q == 2'd1)
  `ASSERT_NEXT(a_cfg_stalls_input, clk_i, rst_ni, cfg_acc, !in_ready_i)

endmodule

bind exponential_moving_average ema_checker u_ema_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .average_i   (out_if.average),
  .valid_res_i (out_if.valid_res),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr)
);

// ===== bench/ema_average_check.sv =====
// Watches the sample and average streams, predicts every average and compares.
module ema_average_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ema_in_if                             sample_ch,
  ema_out_if                            average_ch,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [ema_pkg::AddrWidth-1:0] paddr_i,
  input  logic [ema_pkg::DataWidth-1:0] pwdata_i,
  output int                            failures_o,
  output int                            pending_o
);

  typedef struct packed {
    logic signed [ema_pkg::SampleWidth-1:0] average;
    logic                                   valid_res;
  } ema_out_t;

  logic [ema_pkg::PeriodWidth-1:0]        period_q;
  logic [ema_pkg::WeightBits-1:0]         alpha_q;
  logic [ema_pkg::PeriodWidth-1:0]        seed_n;
  logic signed [ema_pkg::SumWidth-1:0]    seed_total;
  logic signed [ema_pkg::SampleWidth-1:0] ema_q;
  logic                                   locked;
  logic                                   tainted;
  ema_out_t                               due_averages[$];
  int                                     mismatches = 0;

  function automatic int unsigned clamp_period(input logic [ema_pkg::PeriodWidth-1:0] p);
    if (p == '0) begin
      return 1;
    end
    if (p > ema_pkg::MaxPeriod) begin
      return ema_pkg::MaxPeriod;
    end
    return p;
  endfunction

  // 2/(period+1) in unsigned Q1.24, truncated.
  function automatic logic [ema_pkg::WeightBits-1:0] alpha_for(
    input logic [ema_pkg::PeriodWidth-1:0] p);
    longint unsigned two_q24;
    two_q24 = longint'(2) << ema_pkg::WeightFrac;
    return ema_pkg::WeightBits'(two_q24 / (longint'(clamp_period(p)) + 1));
  endfunction

  function automatic logic signed [ema_pkg::SampleWidth-1:0] clip(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (ema_pkg::SampleWidth - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return ema_pkg::SampleWidth'(hi);
    end
    if (v < lo) begin
      return ema_pkg::SampleWidth'(lo);
    end
    return ema_pkg::SampleWidth'(v);
  endfunction

  function automatic ema_out_t advance_ema(input logic signed [ema_pkg::SampleWidth-1:0] x,
                                           input logic miss);
    ema_out_t r;
    longint   divisor;
    longint   prod;
    r = '0;
    if (tainted) begin
      r = '0;
    end else if (miss) begin
      // Absent samples ahead of the stream are skipped; later ones poison it.
      if (seed_n != '0 || locked) begin
        tainted = 1'b1;
      end
    end else if (!locked) begin
      seed_total = seed_total + ema_pkg::SumWidth'(x);
      seed_n     = seed_n + 1'b1;
      if (seed_n == '0 || seed_n >= clamp_period(period_q)) begin
        divisor = (seed_n == '0) ? (longint'(1) << ema_pkg::PeriodWidth) : longint'(seed_n);
        ema_q   = clip(longint'(seed_total) / divisor);
        locked  = 1'b1;
        r.valid_res = 1'b1;
      end
    end else begin
      prod  = (longint'(x) - longint'(ema_q)) * longint'(alpha_q);
      ema_q = clip(longint'(ema_q) + (prod >>> ema_pkg::WeightFrac));
      r.valid_res = 1'b1;
    end
    if (r.valid_res) begin
      r.average = ema_q;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    ema_out_t want;
    ema_out_t got;
    if (!rst_ni) begin
      period_q   = ema_pkg::PeriodReset;
      alpha_q    = alpha_for(ema_pkg::PeriodReset);
      seed_n     = '0;
      seed_total = '0;
      ema_q      = '0;
      locked     = 1'b0;
      tainted    = 1'b0;
      due_averages.delete();
    end else begin
      // Only the period register exists; writes elsewhere are dropped.
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[ema_pkg::AddrWidth-1:2] == ema_pkg::RegPeriod) begin
        period_q = pwdata_i[ema_pkg::PeriodWidth-1:0];
        alpha_q  = alpha_for(period_q);
      end
      if (sample_ch.valid && sample_ch.ready) begin
        due_averages.push_back(advance_ema(sample_ch.sample, sample_ch.missing));
      end
      if (average_ch.valid && average_ch.ready) begin
        got.average   = average_ch.average;
        got.valid_res = average_ch.valid_res;
        if (due_averages.size() == 0) begin
          $error("average transaction with none pending: average %0d valid_res %0b",
                 got.average, got.valid_res);
          mismatches++;
        end else begin
          want = due_averages.pop_front();
          if (got.average !== want.average) begin
            $error("average: expected %0d, got %0d", want.average, got.average);
            mismatches++;
          end
          if (got.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0b, got %0b", want.valid_res, got.valid_res);
            mismatches++;
          end
        end
      end
    end
    failures_o <= mismatches;
    pending_o  <= due_averages.size();
  end

endmodule

// ===== bench/exponential_moving_average_test.sv =====
// Stimulus, stream pacing and verdict for the exponential moving average block.
module exponential_moving_average_test;

  localparam int SeedRun     = 700;
  localparam int PhaseLen    = 100;
  localparam int Phases      = 11;
  localparam int NoiseLen    = 60;
  localparam int LongHold    = 300;
  localparam int DrainCycles = 60;
  localparam int CycleLimit  = 1000000;

  localparam logic [ema_pkg::AddrWidth-1:0] PeriodAddr =
    ema_pkg::AddrWidth'(ema_pkg::RegPeriod) << 2;
  localparam logic [ema_pkg::AddrWidth-1:0] SpareAddr  = PeriodAddr + ema_pkg::AddrWidth'(4);

  localparam logic signed [ema_pkg::SampleWidth-1:0] SampleMax =
    {1'b0, {(ema_pkg::SampleWidth-1){1'b1}}};
  localparam logic signed [ema_pkg::SampleWidth-1:0] SampleMin =
    {1'b1, {(ema_pkg::SampleWidth-1){1'b0}}};
  localparam logic signed [ema_pkg::SampleWidth-1:0] OneQ16 = ema_pkg::SampleWidth'(1) << 16;

  logic                                   clk_i;
  logic                                   rst_ni;
  logic                                   psel;
  logic                                   penable;
  logic                                   pwrite;
  logic                                   pready;
  logic [ema_pkg::AddrWidth-1:0]          paddr;
  logic [ema_pkg::DataWidth-1:0]          pwdata;
  logic [ema_pkg::DataWidth-1:0]          prdata;
  int                                     fail_cnt;
  int                                     due_cnt;
  int                                     cycle_cnt = 0;
  int                                     hold_ask;
  bit                                     no_idle;
  logic signed [ema_pkg::SampleWidth-1:0] last_price;

  ema_in_if  sample_ch ();
  ema_out_if average_ch ();

  exponential_moving_average u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (sample_ch),
    .out_if  (average_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ema_average_check u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_ch  (sample_ch),
    .average_ch (average_ch),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .pready_i   (pready),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .failures_o (fail_cnt),
    .pending_o  (due_cnt)
  );

  initial clk_i = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mostly a random walk around the last price, now and then anywhere in range.
  function automatic logic signed [ema_pkg::SampleWidth-1:0] next_price();
    longint p;
    if ($urandom_range(0, 3) == 0) begin
      return $urandom();
    end
    p = longint'(last_price) + longint'($urandom_range(0, 1 << 21)) - (longint'(1) << 20);
    if (p > SampleMax) begin
      p = SampleMax;
    end
    if (p < SampleMin) begin
      p = SampleMin;
    end
    return ema_pkg::SampleWidth'(p);
  endfunction

  task automatic send_sample(input logic signed [ema_pkg::SampleWidth-1:0] x,
                             input logic miss);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.sample  <= x;
    sample_ch.missing <= miss;
    last_price = x;
    do @(posedge clk_i); while (!sample_ch.ready);
  endtask

  // Hold input until every pending average has come back.
  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (due_cnt != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [ema_pkg::AddrWidth-1:0] addr,
                           input logic [ema_pkg::DataWidth-1:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random upper bits ride along; only the low period bits count.
  task automatic set_period(input int unsigned p);
    logic [ema_pkg::DataWidth-1:0] word;
    settle();
    word = $urandom();
    word[ema_pkg::PeriodWidth-1:0] = ema_pkg::PeriodWidth'(p);
    apb_write(PeriodAddr, word);
  endtask

  initial begin : stimulus
    int unsigned pick;
    rst_ni = 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    sample_ch.valid   <= 1'b0;
    sample_ch.sample  <= '0;
    sample_ch.missing <= 1'b0;
    no_idle  <= 1'b0;
    hold_ask <= 0;
    last_price = OneQ16;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Absent samples ahead of the first real one are skipped.
    send_sample(SampleMax, 1'b1);
    send_sample(SampleMin, 1'b1);
    send_sample('0, 1'b1);
    // Start the seed at the reset period with the rails.
    send_sample(SampleMax, 1'b0);
    send_sample(SampleMin, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(OneQ16, 1'b0);
    settle();
    apb_write(SpareAddr, '1);
    send_sample(-OneQ16, 1'b0);

    // Stretch the seed to the longest period, then cut it below the count reached.
    set_period((1 << ema_pkg::PeriodWidth) - 1);
    for (int i = 0; i < SeedRun; i++) begin
      if (i == SeedRun / 4) begin
        hold_ask <= hold_ask + 1;
      end
      send_sample(next_price(), 1'b0);
    end
    set_period(300);
    send_sample(next_price(), 1'b0);

    // Period zero acts as one: the average tracks each sample exactly.
    set_period(0);
    send_sample(SampleMax, 1'b0);
    send_sample(SampleMin, 1'b0);
    send_sample(SampleMax, 1'b0);
    send_sample('0, 1'b0);
    send_sample(-1, 1'b0);
    set_period(ema_pkg::MaxPeriod);
    send_sample(SampleMin, 1'b0);
    send_sample(SampleMax, 1'b0);

    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: begin
          pick = 1;
        end
        1: begin
          pick = 2;
        end
        2: begin
          pick = ema_pkg::MaxPeriod + 1;
        end
        3: begin
          pick = ema_pkg::MaxPeriod - 1;
        end
        4: begin
          pick = (1 << ema_pkg::PeriodWidth) - 1;
        end
        default: begin
          pick = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 32)
                 : $urandom_range(0, (1 << ema_pkg::PeriodWidth) - 1);
        end
      endcase
      set_period(pick);
      no_idle <= (ph % 3 == 2);
      repeat (PhaseLen) send_sample(next_price(), 1'b0);
      no_idle <= 1'b0;
    end

    // Poison the stream; from here on every result is invalid.
    send_sample(next_price(), 1'b1);
    repeat (NoiseLen) send_sample($urandom(), 1'($urandom_range(0, 1)));

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : drain_side
    int gap;
    int holds_done;
    holds_done = 0;
    average_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_ask != holds_done) begin
        holds_done = hold_ask;
        average_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        average_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      average_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!average_ch.valid);
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
